// ===== rtl/base128_varint_codec_top_defines.svh =====
// Assertion macros shared by the varint codec checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BASE128_VARINT_CODEC_TOP_DEFINES_SVH
`define BASE128_VARINT_CODEC_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define B128VC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define B128VC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/b128vc_pkg.sv =====
// Shared constants and controller/datapath interface types for the varint codec.
// No dependencies.
`timescale 1ns / 1ps

package b128vc_pkg;

  // Field and encoding constants.
  localparam int FIELD_W    = 64;
  localparam int BYTE_W     = 8;
  localparam int GROUP_BITS = 7;
  localparam int MAX_BYTES  = 10;
  localparam int CNT_W      = 4;
  // Widest placement of one group: group nine lands at bit 63 and spans to bit 69.
  localparam int WIDE_W     = GROUP_BITS * MAX_BYTES;
  localparam int SHAMT_W    = $clog2(WIDE_W);

  localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h80;

  // Operation codes.
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic enc_start;  // Load a new value and emit its first byte.
    logic enc_step;   // Emit the next byte of the value in flight.
    logic dec_step;   // Fold one input byte into the decoder.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more_new;   // The value on the input needs more than one byte.
    logic more_cont;  // The value in flight needs more bytes after this one.
  } sts_t;

endpackage

// ===== rtl/b128vc_dp.sv =====
// Datapath of the varint codec: encode shift register, decoder state, result registers.
// Depends on b128vc_pkg.
`timescale 1ns / 1ps

module b128vc_dp #(
  parameter int VALUE_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  b128vc_pkg::cmd_t                  cmd,
  output b128vc_pkg::sts_t                  sts,
  input  logic [b128vc_pkg::FIELD_W-1:0]    in_value_in,
  input  logic [b128vc_pkg::BYTE_W-1:0]     in_byte_in,
  output logic [b128vc_pkg::BYTE_W-1:0]     out_byte_out,
  output logic                              out_last,
  output logic [b128vc_pkg::FIELD_W-1:0]    out_value_out,
  output logic                              out_value_valid,
  output logic                              out_overflow
);

  // Encoder registers.
  logic [VALUE_BITS-1:0]            shift_r, shift_nxt;
  logic [b128vc_pkg::CNT_W-1:0]     ecnt_r, ecnt_nxt;

  // Decoder state.
  logic [VALUE_BITS-1:0]            acc_r, acc_nxt;
  logic [b128vc_pkg::CNT_W-1:0]     gcnt_r, gcnt_nxt;
  logic                             ovf_r, ovf_nxt;

  // Result registers.
  logic [b128vc_pkg::BYTE_W-1:0]    byte_r, byte_nxt;
  logic                             last_r, last_nxt;
  logic [b128vc_pkg::FIELD_W-1:0]   value_r, value_nxt;
  logic                             vvalid_r, vvalid_nxt;
  logic                             rovf_r, rovf_nxt;

  // Encoder combinational signals.
  logic [VALUE_BITS-1:0]            enc_src;
  logic                             enc_more;
  logic [b128vc_pkg::BYTE_W-1:0]    enc_byte;

  // Decoder combinational signals.
  logic [b128vc_pkg::GROUP_BITS-1:0] grp;
  logic [b128vc_pkg::SHAMT_W-1:0]   shamt;
  logic [b128vc_pkg::WIDE_W-1:0]    placed;
  logic [VALUE_BITS-1:0]            acc_upd;
  logic [b128vc_pkg::CNT_W-1:0]     gcnt_upd;
  logic                             ovf_upd;
  logic                             run_end;
  logic [b128vc_pkg::FIELD_W-1:0]   value_ext;

  // Encoder: pick the byte source and decide whether more bytes follow.
  always_comb begin
    enc_src = cmd.enc_start ? in_value_in[VALUE_BITS-1:0] : shift_r;
    sts.more_new  = |in_value_in[VALUE_BITS-1:b128vc_pkg::GROUP_BITS];
    sts.more_cont = (|shift_r[VALUE_BITS-1:b128vc_pkg::GROUP_BITS]) &&
                    (ecnt_r < b128vc_pkg::CNT_W'(b128vc_pkg::MAX_BYTES - 1));
    enc_more = cmd.enc_start ? sts.more_new : sts.more_cont;
    if (enc_more) begin
      enc_byte = b128vc_pkg::CONT_MASK | (enc_src[b128vc_pkg::BYTE_W-1:0] &
                                          b128vc_pkg::GROUP_MASK);
    end else begin
      enc_byte = enc_src[b128vc_pkg::BYTE_W-1:0];
    end
    shift_nxt = enc_src >> b128vc_pkg::GROUP_BITS;
    ecnt_nxt  = cmd.enc_start ? b128vc_pkg::CNT_W'(1) : ecnt_r + 1'b1;
  end

  // Decoder: place the group at bit 7*k; any bit landing past the value width
  // marks overflow, and bytes after the tenth are dropped.
  always_comb begin
    grp     = in_byte_in[b128vc_pkg::GROUP_BITS-1:0];
    shamt   = b128vc_pkg::SHAMT_W'(b128vc_pkg::GROUP_BITS * gcnt_r);
    placed  = b128vc_pkg::WIDE_W'(grp) << shamt;
    run_end = ~in_byte_in[b128vc_pkg::BYTE_W-1];
    acc_upd  = acc_r;
    gcnt_upd = gcnt_r;
    ovf_upd  = ovf_r;
    if (gcnt_r >= b128vc_pkg::CNT_W'(b128vc_pkg::MAX_BYTES)) begin
      ovf_upd = 1'b1;
    end else begin
      acc_upd  = acc_r | placed[VALUE_BITS-1:0];
      gcnt_upd = gcnt_r + 1'b1;
      if (|placed[b128vc_pkg::WIDE_W-1:VALUE_BITS]) begin
        ovf_upd = 1'b1;
      end
    end
    value_ext = '0;
    value_ext[VALUE_BITS-1:0] = acc_upd;
  end

  // Next decoder state: a run that ends returns the state to zero.
  always_comb begin
    acc_nxt  = acc_r;
    gcnt_nxt = gcnt_r;
    ovf_nxt  = ovf_r;
    if (cmd.dec_step) begin
      if (run_end) begin
        acc_nxt  = '0;
        gcnt_nxt = '0;
        ovf_nxt  = 1'b0;
      end else begin
        acc_nxt  = acc_upd;
        gcnt_nxt = gcnt_upd;
        ovf_nxt  = ovf_upd;
      end
    end
  end

  // Next result register contents.
  always_comb begin
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    value_nxt  = value_r;
    vvalid_nxt = vvalid_r;
    rovf_nxt   = rovf_r;
    if (cmd.enc_start || cmd.enc_step) begin
      byte_nxt   = enc_byte;
      last_nxt   = ~enc_more;
      value_nxt  = '0;
      vvalid_nxt = 1'b0;
      rovf_nxt   = 1'b0;
    end else if (cmd.dec_step) begin
      byte_nxt   = '0;
      last_nxt   = 1'b0;
      value_nxt  = run_end ? value_ext : '0;
      vvalid_nxt = run_end;
      rovf_nxt   = run_end & ovf_upd;
    end
  end

  // Decoder state and encoder counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      gcnt_r <= '0;
      ovf_r  <= 1'b0;
      ecnt_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      gcnt_r <= gcnt_nxt;
      ovf_r  <= ovf_nxt;
      if (cmd.enc_start || cmd.enc_step) begin
        ecnt_r <= ecnt_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.enc_start || cmd.enc_step) begin
      shift_r <= shift_nxt;
    end
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    value_r  <= value_nxt;
    vvalid_r <= vvalid_nxt;
    rovf_r   <= rovf_nxt;
  end

  assign out_byte_out    = byte_r;
  assign out_last        = last_r;
  assign out_value_out   = value_r;
  assign out_value_valid = vvalid_r;
  assign out_overflow    = rovf_r;

endmodule

// ===== rtl/b128vc_ctrl.sv =====
// Controller of the varint codec: sequences encode runs and owns both handshakes.
// Depends on b128vc_pkg.
`timescale 1ns / 1ps

module b128vc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  output logic              out_valid,
  input  logic              out_ready,
  output b128vc_pkg::cmd_t  cmd,
  input  b128vc_pkg::sts_t  sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ENC  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot;

  // The result register can take a new result when empty or being drained.
  assign slot = ~out_valid_r | out_ready;

  // Next-state and command logic.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = slot;
        if (in_valid && slot) begin
          out_valid_nxt = 1'b1;
          if (in_op == b128vc_pkg::OP_ENCODE) begin
            cmd.enc_start = 1'b1;
            if (sts.more_new) begin
              state_nxt = ST_ENC;
            end
          end else begin
            cmd.dec_step = 1'b1;
          end
        end
      end
      ST_ENC: begin
        if (slot) begin
          cmd.enc_step  = 1'b1;
          out_valid_nxt = 1'b1;
          if (!sts.more_cont) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/base128_varint_codec_top.sv =====
// Unsigned base-128 varint codec. An encode transaction (op 0) yields one to ten
// output bytes, least significant seven-bit group first, one per cycle while the
// output is not stalled; the first byte is produced in the cycle the input is
// taken, and the next input is taken once the last byte has entered the output
// register. A decode transaction (op 1) takes one byte per cycle while the output
// is not stalled and always gives one result; the byte without bit 7 ends the
// run and its result carries the value with value_valid set, and overflow if bits
// beyond VALUE_BITS were nonzero or more than ten bytes came. A full output
// register that is not drained stalls input.
// Depends on b128vc_pkg, b128vc_ctrl and b128vc_dp.
`timescale 1ns / 1ps

module base128_varint_codec_top #(
  parameter int VALUE_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [b128vc_pkg::FIELD_W-1:0]  in_value_in,
  input  logic [b128vc_pkg::BYTE_W-1:0]   in_byte_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [b128vc_pkg::BYTE_W-1:0]   out_byte_out,
  output logic                            out_last,
  output logic [b128vc_pkg::FIELD_W-1:0]  out_value_out,
  output logic                            out_value_valid,
  output logic                            out_overflow
);

  b128vc_pkg::cmd_t cmd;
  b128vc_pkg::sts_t sts;

  // Sequencing and handshakes.
  b128vc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Encode and decode datapath.
  b128vc_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_value_in     (in_value_in),
    .in_byte_in      (in_byte_in),
    .out_byte_out    (out_byte_out),
    .out_last        (out_last),
    .out_value_out   (out_value_out),
    .out_value_valid (out_value_valid),
    .out_overflow    (out_overflow)
  );

endmodule

// ===== rtl/b128vc_checker.sv =====
// Port-level checker for the varint codec, bound to the top level.
// Depends on base128_varint_codec_top_defines.svh and b128vc_pkg.
`timescale 1ns / 1ps
`include "base128_varint_codec_top_defines.svh"

module b128vc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [b128vc_pkg::BYTE_W-1:0]   out_byte_out,
  input logic                            out_last,
  input logic [b128vc_pkg::FIELD_W-1:0]  out_value_out,
  input logic                            out_value_valid,
  input logic                            out_overflow
);

  // A stalled result transaction keeps its payload.
  `B128VC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte_out) && $stable(out_last) && $stable(out_value_out) && $stable(out_value_valid) && $stable(out_overflow), "stalled result changed")

  // The final byte of an encode run carries no continuation bit.
  `B128VC_ASSERT(a_last_no_cont, clk, rst_n, out_valid && out_last |-> !out_byte_out[b128vc_pkg::BYTE_W-1], "last byte has continuation bit")

  // A decoded value never comes with encode fields.
  `B128VC_ASSERT(a_value_excl, clk, rst_n, out_valid && out_value_valid |-> !out_last && (out_byte_out == '0), "decode result carries encode fields")

  // Overflow is reported only with a finished value.
  `B128VC_ASSERT(a_ovf_with_value, clk, rst_n, out_valid && out_overflow |-> out_value_valid, "overflow without value")

  // Reset empties the result register.
  `B128VC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind base128_varint_codec_top b128vc_checker u_b128vc_checker (.*);

// ===== bench/tb_base128_varint_codec_top.sv =====
// Self-checking testbench for base128_varint_codec_top: directed and random encode
// values and decode byte streams, with results checked against a built-in codec model.
// Depends on b128vc_pkg and the codec RTL.
`timescale 1ns / 1ps

module tb_base128_varint_codec_top;

  localparam int RANDOM_ITEMS = 160;
  localparam int HOLD_AT      = 50;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [b128vc_pkg::FIELD_W-1:0] word_t;
  typedef logic [b128vc_pkg::BYTE_W-1:0]  byte_t;

  // One input transaction.
  typedef struct {
    logic  op;
    word_t value;
    byte_t code_byte;
  } request_t;

  // One output transaction.
  typedef struct {
    byte_t byte_out;
    logic  last;
    word_t value_out;
    logic  value_valid;
    logic  overflow;
  } result_t;

  logic  clk             = 1'b0;
  logic  rst_n           = 1'b0;
  logic  in_valid        = 1'b0;
  logic  in_ready;
  logic  in_op           = b128vc_pkg::OP_ENCODE;
  word_t in_value_in     = '0;
  byte_t in_byte_in      = '0;
  logic  out_valid;
  logic  out_ready       = 1'b0;
  byte_t out_byte_out;
  logic  out_last;
  word_t out_value_out;
  logic  out_value_valid;
  logic  out_overflow;

  request_t queued_requests[$];
  result_t  predicted_results[$];

  // Decoder state of the model, at its reset values.
  word_t                          model_acc    = '0;
  logic [b128vc_pkg::CNT_W-1:0]   model_groups = '0;
  logic                           model_ovf    = 1'b0;

  int error_count    = 0;
  int total_requests = 0;
  int requests_taken = 0;
  int results_seen   = 0;

  base128_varint_codec_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value_in     (in_value_in),
    .in_byte_in      (in_byte_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_out    (out_byte_out),
    .out_last        (out_last),
    .out_value_out   (out_value_out),
    .out_value_valid (out_value_valid),
    .out_overflow    (out_overflow)
  );

  always #6 clk = ~clk;

  // Work out the results of one accepted transaction and update the decoder state.
  function automatic void predict_codec(request_t req);
    word_t   rest;
    word_t   grp;
    result_t res;
    int      n;
    int      shift;
    res = '{default: '0};
    if (req.op == b128vc_pkg::OP_ENCODE) begin
      // Low group first; the tenth byte takes whatever is left.
      rest = req.value;
      n = 0;
      while (rest > word_t'(b128vc_pkg::GROUP_MASK) && n < b128vc_pkg::MAX_BYTES - 1) begin
        res.byte_out = (rest[b128vc_pkg::BYTE_W-1:0] & b128vc_pkg::GROUP_MASK) |
                       b128vc_pkg::CONT_MASK;
        predicted_results.push_back(res);
        rest = rest >> b128vc_pkg::GROUP_BITS;
        n++;
      end
      res.byte_out = rest[b128vc_pkg::BYTE_W-1:0];
      res.last = 1'b1;
      predicted_results.push_back(res);
    end else begin
      grp = word_t'(req.code_byte & b128vc_pkg::GROUP_MASK);
      if (model_groups >= b128vc_pkg::MAX_BYTES) begin
        // Bytes past the tenth are dropped.
        model_ovf = 1'b1;
      end else begin
        shift = b128vc_pkg::GROUP_BITS * model_groups;
        if (shift >= b128vc_pkg::FIELD_W) begin
          if (grp != '0) model_ovf = 1'b1;
        end else begin
          if (b128vc_pkg::FIELD_W - shift < b128vc_pkg::GROUP_BITS &&
              (grp >> (b128vc_pkg::FIELD_W - shift)) != '0) begin
            model_ovf = 1'b1;
          end
          model_acc = model_acc | (grp << shift);
        end
        model_groups++;
      end
      // A byte without the continuation bit closes the run.
      if ((req.code_byte & b128vc_pkg::CONT_MASK) == '0) begin
        res.value_out   = model_acc;
        res.value_valid = 1'b1;
        res.overflow    = model_ovf;
        model_acc       = '0;
        model_groups    = '0;
        model_ovf       = 1'b0;
      end
      predicted_results.push_back(res);
    end
  endfunction

  // The unused field of each transaction carries random data.
  function automatic void add_encode(word_t v);
    request_t req;
    req.op        = b128vc_pkg::OP_ENCODE;
    req.value     = v;
    req.code_byte = byte_t'($urandom);
    queued_requests.push_back(req);
  endfunction

  function automatic void add_decode(byte_t b);
    request_t req;
    req.op        = b128vc_pkg::OP_DECODE;
    req.value     = {$urandom, $urandom};
    req.code_byte = b;
    queued_requests.push_back(req);
  endfunction

  // Queue the encoded bytes of a value, optionally padded with redundant zero groups.
  // A ten-byte run sometimes gets a final group with bits beyond bit 63.
  function automatic void add_decode_run(word_t v, int pad);
    byte_t run[$];
    word_t rest;
    rest = v;
    do begin
      run.push_back({(rest >> b128vc_pkg::GROUP_BITS) != '0,
                     rest[b128vc_pkg::GROUP_BITS-1:0]});
      rest = rest >> b128vc_pkg::GROUP_BITS;
    end while (rest != '0);
    if (run.size() == b128vc_pkg::MAX_BYTES && $urandom_range(0, 3) == 0) begin
      run[$] = byte_t'($urandom_range(2, 127));
    end
    if (pad > 0) begin
      run[$] = run[$] | b128vc_pkg::CONT_MASK;
      repeat (pad - 1) run.push_back(b128vc_pkg::CONT_MASK);
      run.push_back('0);
    end
    foreach (run[i]) add_decode(run[i]);
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("MISMATCH %0t ns result %0d %s: got %h, want %h",
             $time, results_seen, what, got, want);
    error_count++;
  endtask

  // Driver: offers queued transactions with a random gap after each accepted one.
  int       gap_left = 0;
  logic     offer;
  request_t current_request;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        predict_codec(current_request);
        requests_taken++;
        offer = 1'b0;
        // Every third stretch of transactions goes back to back.
        gap_left = (((requests_taken / 30) % 3) == 1) ? 0 : $urandom_range(0, 10);
      end
      if (!offer && queued_requests.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          current_request = queued_requests.pop_front();
          in_op       <= current_request.op;
          in_value_in <= current_request.value;
          in_byte_in  <= current_request.code_byte;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Monitor: checks each result and stalls at random; once it holds off long enough
  // for the codec to back up into its input.
  int      stall_left = 0;
  int      hold_left  = 0;
  logic    take;
  result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result, value_out", out_value_out, '0);
        end else begin
          want = predicted_results.pop_front();
          if (out_byte_out !== want.byte_out)
            report_mismatch("byte_out", word_t'(out_byte_out), word_t'(want.byte_out));
          if (out_last !== want.last)
            report_mismatch("last", word_t'(out_last), word_t'(want.last));
          if (out_value_out !== want.value_out)
            report_mismatch("value_out", out_value_out, want.value_out);
          if (out_value_valid !== want.value_valid)
            report_mismatch("value_valid", word_t'(out_value_valid),
                            word_t'(want.value_valid));
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", word_t'(out_overflow), word_t'(want.overflow));
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
        stall_left = (((results_seen / 40) % 3) == 2) ? 0 : $urandom_range(0, 10);
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_ready <= take;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    word_t rand_value;
    int    directed_total;
    int    pick;

    // Encode extremes: one-byte limits, two-byte limits, the smallest three-byte value, ten-byte values.
    add_encode('0);
    add_encode(64'h7F);
    add_encode(64'h80);
    add_encode(64'h3FFF);
    add_encode(64'h4000);
    add_encode(64'h8000_0000_0000_0000);
    add_encode('1);

    // Short decode runs.
    add_decode_run('0, 0);
    add_decode_run(64'd128, 0);

    // Eleven-byte decode run: the tenth group spills past bit 63 and the eleventh
    // byte is one too many. An encode in the middle must not disturb the run.
    repeat (5) add_decode(8'hFF);
    add_encode(64'h0123_4567_89AB_CDEF);
    repeat (4) add_decode(8'hFF);
    add_decode(8'hFE);
    add_decode(8'h00);
    directed_total = queued_requests.size();

    // Mostly well-formed encodes and decode runs of random length, some noise bytes.
    while (queued_requests.size() < directed_total + RANDOM_ITEMS) begin
      rand_value = {$urandom, $urandom} >>
                   (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 63));
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        add_encode(rand_value);
      end else if (pick < 8) begin
        add_decode_run(rand_value, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
      end else begin
        repeat ($urandom_range(1, 3)) add_decode(byte_t'($urandom));
      end
    end
    total_requests = queued_requests.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_taken != total_requests) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("base128_varint_codec_top verification clean");
    end else begin
      $display("base128_varint_codec_top verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("base128_varint_codec_top verification failed");
    $finish;
  end

endmodule
